// File: rtl/pn2_pkg.sv
// ----------------------------------------------------------------------------
// pn2_pkg
// Shared constants and the gradient table builder for the 2-D gradient noise
// pipeline.
// ----------------------------------------------------------------------------
package pn2_pkg;

	// Corner hash multipliers.
	localparam logic [31:0] HASH_M1 = 32'd3284157443;
	localparam logic [31:0] HASH_M2 = 32'd1911520717;
	localparam logic [31:0] HASH_M3 = 32'd2048419325;

	// Internal fraction width of offsets and weights (Q0.24).
	localparam int WFRAC = 24;

	// Number of corners of one lattice cell.
	localparam int CORNERS = 4;

	// Quadrant codes taken from the top two hash bits.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Rotation angles in units of 2^-32 turn, and the gain-compensated start.
	localparam int CORDIC_ITERS = 16;
	localparam longint CORDIC_X0 = 64'sd652032874;
	localparam longint ARC_TURN [CORDIC_ITERS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef logic [31:0] word_t;

	// Rounds a value at scale 2^30 to Q1.14 and clamps it to plus or minus one.
	function automatic logic signed [15:0] to_q14(longint v);
		longint r;
		r = (v + 64'sd32768) >>> 16;
		if (r > 64'sd16384) r = 64'sd16384;
		if (r < -64'sd16384) r = -64'sd16384;
		return 16'(r);
	endfunction

	// Builds one table entry {cos, sin} for residual angle index r within the
	// first quadrant, evaluated at elaboration only.
	function automatic logic [31:0] grad_entry(int unsigned r, int angle_bits);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = CORDIC_X0;
		y = 0;
		z = longint'(r) <<< (32 - angle_bits);
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARC_TURN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARC_TURN[i];
			end
		end
		return {to_q14(x), to_q14(y)};
	endfunction

endpackage

// File: rtl/pn2_grad.sv
// ----------------------------------------------------------------------------
// pn2_grad
// Gradient lookup for the four corners: a quarter-turn constant table read
// into registers, then rotated into the quadrant that the hash selects.
// ----------------------------------------------------------------------------
module pn2_grad
	import pn2_pkg::*;
#(
	parameter int ANGLE_BITS = 10
) (
	input  logic               clk,
	input  word_t              hash [CORNERS],
	output logic signed [15:0] grad_x [CORNERS],
	output logic signed [15:0] grad_y [CORNERS]
);

	localparam int RES_BITS = ANGLE_BITS - 2;
	localparam int TBL_SIZE = 1 << RES_BITS;

	logic [31:0]        rom [TBL_SIZE];
	logic signed [15:0] cos_s4 [CORNERS];
	logic signed [15:0] sin_s4 [CORNERS];
	logic [1:0]         quad_s4 [CORNERS];

	// Table contents are fixed at elaboration.
	for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
		assign rom[k] = grad_entry(k, ANGLE_BITS);
	end

	// Registered lookup of the residual angle for every corner.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CORNERS; c++) begin
			cos_s4[c]  <= rom[hash[c][31-2 -: RES_BITS]][31:16];
			sin_s4[c]  <= rom[hash[c][31-2 -: RES_BITS]][15:0];
			quad_s4[c] <= hash[c][31:30];
		end
	end

	// Rotate the first-quadrant vector into place.
	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			unique case (quad_s4[c])
				QUAD_0: begin grad_x[c] = cos_s4[c];  grad_y[c] = sin_s4[c];  end
				QUAD_1: begin grad_x[c] = -sin_s4[c]; grad_y[c] = cos_s4[c];  end
				QUAD_2: begin grad_x[c] = -cos_s4[c]; grad_y[c] = -sin_s4[c]; end
				QUAD_3: begin grad_x[c] = sin_s4[c];  grad_y[c] = -cos_s4[c]; end
				default: begin grad_x[c] = cos_s4[c]; grad_y[c] = sin_s4[c];  end
			endcase
		end
	end

endmodule

// File: rtl/perlin_noise_2d.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d
// Two-dimensional gradient noise: one signed Q16.16 point in, one Q2.14
// noise value out.
// ----------------------------------------------------------------------------
// The block is a ten-stage pipeline that takes a new point in every cycle:
// busy is always low, and each result appears on noise_value with done high
// for one cycle, once its transaction has passed the last stage. The depth is set
// by the chain of three hash multiplications, the registered gradient table
// read, the dot products and the two blend multiplications. The receiver
// cannot stall the pipeline, so results must be captured when done is high.
// ----------------------------------------------------------------------------
module perlin_noise_2d
	import pn2_pkg::*;
#(
	parameter int ANGLE_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               done,
	output logic signed [15:0] noise_value
);

	localparam int DEPTH = 10;
	localparam logic [WFRAC+1:0] ONE = 26'(1) << WFRAC;
	localparam logic [WFRAC+1:0] THREE = 26'(3) << WFRAC;

	logic [DEPTH-1:0] vld_q;

	// Stage 1 registers
	word_t             ax0_s1, ax1_s1, y0_s1, y1_s1;
	logic [WFRAC-1:0]  fx_s1, fy_s1, tx2_s1, ty2_s1;
	// Stage 2 registers
	word_t             b_s2 [CORNERS];
	word_t             ax0_s2, ax1_s2;
	logic [WFRAC-1:0]  fx_s2, fy_s2;
	logic [WFRAC:0]    wx_s2, wy_s2;
	// Stage 3 registers
	word_t             h_s3 [CORNERS];
	logic [WFRAC-1:0]  fx_s3, fy_s3;
	logic [WFRAC:0]    wx_s3, wy_s3;
	// Stage 4 (table read inside pn2_grad)
	logic signed [15:0] gx_s4 [CORNERS];
	logic signed [15:0] gy_s4 [CORNERS];
	logic [WFRAC-1:0]  fx_s4, fy_s4;
	logic [WFRAC:0]    wx_s4, wy_s4;
	// Stage 5 to 9 registers
	logic signed [41:0] px_s5 [CORNERS];
	logic signed [41:0] py_s5 [CORNERS];
	logic [WFRAC:0]     wx_s5, wy_s5, wx_s6, wy_s6, wy_s7, wy_s8;
	logic signed [33:0] dot_s6 [CORNERS];
	logic signed [60:0] pt_s7, pb_s7, pv_s9;
	logic signed [33:0] n0_s7, n2_s7, top_s8, bot_s8, top_s9;

	logic signed [31:0] x0, y0;
	logic signed [25:0] ox [CORNERS];
	logic signed [25:0] oy [CORNERS];
	logic signed [34:0] sum_r;
	logic signed [18:0] rnd_r;

	// Fraction of a coordinate widened to Q0.24.
	function automatic logic [WFRAC-1:0] fx_in(logic signed [31:0] c);
		return WFRAC'(c[FRAC_BITS-1:0]) << (WFRAC - FRAC_BITS);
	endfunction

	assign busy = 1'b0;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], start};
		end
	end
	assign done = vld_q[DEPTH-1];

	// Stage 1: cell split, first hash multiply, fade squares.
	assign x0 = coord_x >>> FRAC_BITS;
	assign y0 = coord_y >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		ax0_s1 <= 32'(word_t'(x0) * HASH_M1);
		ax1_s1 <= 32'((word_t'(x0) + 32'd1) * HASH_M1);
		y0_s1  <= word_t'(y0);
		y1_s1  <= word_t'(y0) + 32'd1;
		fx_s1  <= WFRAC'(coord_x[FRAC_BITS-1:0]) << (WFRAC - FRAC_BITS);
		fy_s1  <= WFRAC'(coord_y[FRAC_BITS-1:0]) << (WFRAC - FRAC_BITS);
		tx2_s1 <= WFRAC'(((48'(fx_in(coord_x))) * 48'(fx_in(coord_x))) >> WFRAC);
		ty2_s1 <= WFRAC'(((48'(fx_in(coord_y))) * 48'(fx_in(coord_y))) >> WFRAC);
	end

	// Stage 2: second hash multiply per corner, fade weights.
	always_ff @(posedge clk) begin
		b_s2[0] <= 32'((y0_s1 ^ {ax0_s1[15:0], ax0_s1[31:16]}) * HASH_M2);
		b_s2[1] <= 32'((y0_s1 ^ {ax1_s1[15:0], ax1_s1[31:16]}) * HASH_M2);
		b_s2[2] <= 32'((y1_s1 ^ {ax0_s1[15:0], ax0_s1[31:16]}) * HASH_M2);
		b_s2[3] <= 32'((y1_s1 ^ {ax1_s1[15:0], ax1_s1[31:16]}) * HASH_M2);
		ax0_s2  <= ax0_s1;
		ax1_s2  <= ax1_s1;
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
		wx_s2   <= (WFRAC+1)'(((52'(THREE) - 52'({fx_s1, 1'b0})) * 52'(tx2_s1)) >> WFRAC);
		wy_s2   <= (WFRAC+1)'(((52'(THREE) - 52'({fy_s1, 1'b0})) * 52'(ty2_s1)) >> WFRAC);
	end

	// Stage 3: final hash multiply per corner.
	always_ff @(posedge clk) begin
		h_s3[0] <= 32'((ax0_s2 ^ {b_s2[0][15:0], b_s2[0][31:16]}) * HASH_M3);
		h_s3[1] <= 32'((ax1_s2 ^ {b_s2[1][15:0], b_s2[1][31:16]}) * HASH_M3);
		h_s3[2] <= 32'((ax0_s2 ^ {b_s2[2][15:0], b_s2[2][31:16]}) * HASH_M3);
		h_s3[3] <= 32'((ax1_s2 ^ {b_s2[3][15:0], b_s2[3][31:16]}) * HASH_M3);
		fx_s3   <= fx_s2;
		fy_s3   <= fy_s2;
		wx_s3   <= wx_s2;
		wy_s3   <= wy_s2;
	end

	// Stage 4: gradient table read.
	pn2_grad #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_grad (
		.clk    (clk),
		.hash   (h_s3),
		.grad_x (gx_s4),
		.grad_y (gy_s4)
	);
	always_ff @(posedge clk) begin
		fx_s4 <= fx_s3;
		fy_s4 <= fy_s3;
		wx_s4 <= wx_s3;
		wy_s4 <= wy_s3;
	end

	// Corner offsets: far corners sit one unit further on.
	always_comb begin
		ox[0] = signed'({2'b00, fx_s4});
		ox[2] = ox[0];
		ox[1] = signed'({2'b00, fx_s4} - ONE);
		ox[3] = ox[1];
		oy[0] = signed'({2'b00, fy_s4});
		oy[1] = oy[0];
		oy[2] = signed'({2'b00, fy_s4} - ONE);
		oy[3] = oy[2];
	end

	// Stage 5: offset by gradient products.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CORNERS; c++) begin
			px_s5[c] <= ox[c] * gx_s4[c];
			py_s5[c] <= oy[c] * gy_s4[c];
		end
		wx_s5 <= wx_s4;
		wy_s5 <= wy_s4;
	end

	// Stage 6: dot products at scale 2^30.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CORNERS; c++) begin
			dot_s6[c] <= 34'((px_s5[c] + py_s5[c]) >>> 8);
		end
		wx_s6 <= wx_s5;
		wy_s6 <= wy_s5;
	end

	// Stage 7: blend products along x.
	always_ff @(posedge clk) begin
		pt_s7 <= (35'(dot_s6[1]) - 35'(dot_s6[0])) * signed'({1'b0, wx_s6});
		pb_s7 <= (35'(dot_s6[3]) - 35'(dot_s6[2])) * signed'({1'b0, wx_s6});
		n0_s7 <= dot_s6[0];
		n2_s7 <= dot_s6[2];
		wy_s7 <= wy_s6;
	end

	// Stage 8: blended top and bottom rows.
	always_ff @(posedge clk) begin
		top_s8 <= n0_s7 + 34'(pt_s7 >>> WFRAC);
		bot_s8 <= n2_s7 + 34'(pb_s7 >>> WFRAC);
		wy_s8  <= wy_s7;
	end

	// Stage 9: blend product along y.
	always_ff @(posedge clk) begin
		pv_s9  <= (35'(bot_s8) - 35'(top_s8)) * signed'({1'b0, wy_s8});
		top_s9 <= top_s8;
	end

	// Stage 10: final blend, round half up to Q2.14 and saturate.
	assign sum_r = 35'(top_s9) + 35'(pv_s9 >>> WFRAC);
	assign rnd_r = 19'((sum_r + 35'sd32768) >>> 16);
	always_ff @(posedge clk) begin
		if (rnd_r > 19'sd32767) begin
			noise_value <= 16'sh7FFF;
		end else if (rnd_r < -19'sd32768) begin
			noise_value <= 16'sh8000;
		end else begin
			noise_value <= 16'(rnd_r);
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2-D gradient noise pipeline. Points are sent as
// command transactions; each noise value is typed in or modelled bit-exactly
// (hash, angle table, dot products, smoothstep blend) and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import pn2_pkg::*;

	localparam int ANGLE_BITS = 10;
	localparam int FRAC_BITS  = 16;
	localparam int N_RANDOM   = 1830;
	localparam int PIPE_DEPTH = 10;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic               done;
	logic signed [15:0] noise_value;

	logic signed [15:0] noise_queue [$];
	int                 error_count;
	int                 idle_pct;

	// One directed point; want_valid marks a value typed in by hand.
	typedef struct {
		logic [31:0]        px;
		logic [31:0]        py;
		bit                 want_valid;
		logic signed [15:0] want;
	} point_row_t;

	point_row_t point_table [] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 16'sd0},
		'{32'h0001_0000, 32'h0000_0000, 1'b1, 16'sd0},
		'{32'h0000_0000, 32'hFFFF_0000, 1'b1, 16'sd0},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, 16'sd0},
		'{32'h7FFF_0000, 32'h7FFF_0000, 1'b1, 16'sd0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'sd0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'sd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'sd0},
		'{32'h0000_8000, 32'h0000_8000, 1'b0, 16'sd0},
		'{32'h0000_0001, 32'h0000_FFFF, 1'b0, 16'sd0},
		'{32'h0000_FFFF, 32'h0000_0001, 1'b0, 16'sd0},
		'{32'h7FFF_8000, 32'hFFFF_8000, 1'b0, 16'sd0},
		'{32'hFFFF_8000, 32'h7FFF_8000, 1'b0, 16'sd0},
		'{32'h0003_4000, 32'hFFFD_C000, 1'b0, 16'sd0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'sd0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'sd0},
		'{32'h0012_3456, 32'h00AB_CDEF, 1'b0, 16'sd0},
		'{32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 16'sd0}
	};

	perlin_noise_2d #(
		.ANGLE_BITS(ANGLE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.done       (done),
		.noise_value(noise_value)
	);

	// Floor shift of a signed value.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] swap_halves(logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// Multiply, xor and rotate hash of one lattice corner.
	function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
		logic [31:0] a;
		logic [31:0] b;
		a = cx * HASH_M1;
		b = (cy ^ swap_halves(a)) * HASH_M2;
		a = a ^ swap_halves(b);
		return a * HASH_M3;
	endfunction

	// Rounds a 2^30-scaled component to Q1.14 with clamping.
	function automatic longint unit_q14(longint v);
		longint r;
		r = floor_shift(v + 64'sd32768, 16);
		if (r > 64'sd16384) r = 64'sd16384;
		if (r < -64'sd16384) r = -64'sd16384;
		return r;
	endfunction

	// Unit gradient from the top hash bits, by rotation in sixteen steps.
	function automatic void hash_gradient(input logic [31:0] h, output longint gx,
			output longint gy);
		logic [31:0] turn;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		longint      c;
		longint      s;
		turn = (h >> (32 - ANGLE_BITS)) << (32 - ANGLE_BITS);
		x = CORDIC_X0;
		y = 0;
		z = longint'({2'b00, turn[29:0]});
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - ARC_TURN[i];
			end else begin
				x = x + dx; y = y - dy; z = z + ARC_TURN[i];
			end
		end
		c = unit_q14(x);
		s = unit_q14(y);
		case (turn[31:30])
			QUAD_0: begin gx = c; gy = s; end
			QUAD_1: begin gx = -s; gy = c; end
			QUAD_2: begin gx = -c; gy = -s; end
			default: begin gx = s; gy = -c; end
		endcase
	endfunction

	function automatic longint corner_influence(logic [31:0] cx, logic [31:0] cy,
			longint ox, longint oy);
		longint gx;
		longint gy;
		hash_gradient(lattice_hash(cx, cy), gx, gy);
		return floor_shift(ox * gx + oy * gy, 8);
	endfunction

	function automatic longint lerp_q24(longint a, longint b, longint w);
		return a + floor_shift((b - a) * w, WFRAC);
	endfunction

	function automatic longint smooth_weight(longint t);
		longint t2;
		t2 = (t * t) >>> WFRAC;
		return (((64'sd3 <<< WFRAC) - 2 * t) * t2) >>> WFRAC;
	endfunction

	// Expected noise value of one point.
	function automatic logic signed [15:0] predict_noise(logic [31:0] px,
			logic [31:0] py);
		logic [31:0] x0;
		logic [31:0] y0;
		longint      one;
		longint      fx;
		longint      fy;
		longint      wx;
		longint      wy;
		longint      top;
		longint      bot;
		longint      v;
		x0 = 32'(floor_shift(longint'($signed(px)), FRAC_BITS));
		y0 = 32'(floor_shift(longint'($signed(py)), FRAC_BITS));
		one = 64'sd1 <<< WFRAC;
		fx = longint'(px[FRAC_BITS-1:0]) <<< (WFRAC - FRAC_BITS);
		fy = longint'(py[FRAC_BITS-1:0]) <<< (WFRAC - FRAC_BITS);
		wx = smooth_weight(fx);
		wy = smooth_weight(fy);
		top = lerp_q24(corner_influence(x0, y0, fx, fy),
			corner_influence(x0 + 32'd1, y0, fx - one, fy), wx);
		bot = lerp_q24(corner_influence(x0, y0 + 32'd1, fx, fy - one),
			corner_influence(x0 + 32'd1, y0 + 32'd1, fx - one, fy - one), wx);
		v = floor_shift(lerp_q24(top, bot, wy) + 64'sd32768, 16);
		if (v > 64'sd32767) v = 64'sd32767;
		if (v < -64'sd32768) v = -64'sd32768;
		return 16'(v);
	endfunction

	// Clock generation.
	always #1 clk = ~clk;

	// Run limit.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result checking on every done strobe.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (noise_queue.size() == 0) begin
				$display("%0t: unexpected noise value %0d", $time, noise_value);
				error_count++;
			end else begin
				if (noise_value !== noise_queue[0]) begin
					$display("%0t: noise_value expected %0d actual %0d", $time,
						noise_queue[0], noise_value);
					error_count++;
				end
				void'(noise_queue.pop_front());
			end
		end
	end

	// Sends one point as a transaction and stores its expected value.
	task automatic send_point(logic [31:0] px, logic [31:0] py, bit hand_valid,
			logic signed [15:0] hand_want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		coord_x <= px;
		coord_y <= py;
		@(posedge clk);
		while (busy) @(posedge clk);
		noise_queue.push_back(hand_valid ? hand_want : predict_noise(px, py));
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return (($urandom_range(1) != 0) ? 32'hFFFC_0000 : 32'h0000_0000)
				| (32'($urandom_range(3)) << 16) | 32'($urandom_range(16'hFFFF));
			2: return {16'($urandom_range(16'hFFFF)), 16'h0000}
				| ($urandom_range(1) ? 32'h0000_FFFF : 32'h0000_0000);
			default: return 32'($signed($urandom_range(40)) - 20) << 16
				| $urandom_range(16'hFFFF);
		endcase
	endfunction

	// Stimulus.
	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		coord_x = '0;
		coord_y = '0;
		error_count = 0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points.
		foreach (point_table[i])
			send_point(point_table[i].px, point_table[i].py,
				point_table[i].want_valid, point_table[i].want);
		start <= 1'b0;
		while (noise_queue.size() != 0) @(posedge clk);

		// Random points over three idling phases.
		for (int n = 0; n < N_RANDOM; n++) begin
			idle_pct = (n < N_RANDOM / 3) ? 38 : (n < 2 * N_RANDOM / 3) ? 62 : 0;
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				while (noise_queue.size() != 0) @(posedge clk);
			end
			send_point(random_coord(), random_coord(), 1'b0, 16'sd0);
		end
		start <= 1'b0;

		// Drain.
		waited = 0;
		while (noise_queue.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (error_count == 0 && noise_queue.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/pn2_pkg.sv
rtl/pn2_grad.sv
rtl/perlin_noise_2d.sv
bench/tb_top.sv
